@@ sv/btm_pkg.sv @@
// ----------------------------------------------------------------------------
// btm_pkg
// Widths, row codes and the per-item side record of the bone transform core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package btm_pkg;

  // prescaled vector component and its products
  localparam int RW   = 25;
  localparam int PW   = 2 * RW;
  localparam int KW   = PW + 1;
  localparam int DTW  = PW + 2;
  // difference of two input points before saturation or prescale
  localparam int DFW  = 34;
  // translation component
  localparam int TW   = 25;
  // root pipeline
  localparam int SQN  = 32;
  localparam int SQW  = 2 * SQN;
  localparam int RMW  = SQN + 2;
  // cross magnitude normalization
  localparam int KTW  = 31;
  localparam int EXB  = PW - KTW;
  localparam int EW   = 5;
  localparam int LKW  = SQN + EXB;
  // fraction dividers
  localparam int DVW  = LKW + 2;
  localparam int NDIV = 5;
  // rotation element port width
  localparam int OW   = 18;

  localparam logic [15:0] THR_RESET = 16'd1;

  localparam logic signed [DFW-1:0] T_MAX = 34'sd16777215;
  localparam logic signed [DFW-1:0] T_MIN = -34'sd16777216;

  localparam logic [1:0] ROW_FIRST = 2'd0;
  localparam logic [1:0] ROW_MID   = 2'd1;
  localparam logic [1:0] ROW_LAST  = 2'd2;

  typedef struct packed {
    logic [2:0][TW-1:0] t;
    logic               dneg;
    logic [PW-1:0]      dmag;
    logic [2:0]         kneg;
    logic [2:0][PW-1:0] kmag;
    logic [EW-1:0]      e;
    logic               degen;
  } side_t;

endpackage

`default_nettype wire

@@ sv/bone_transform_matrix_core.sv @@
// ----------------------------------------------------------------------------
// bone_transform_matrix_core
// Rodrigues rotation plus translation of a bone from its rest pose to a moved
// pose, delivered as three matrix rows per bone.
// ----------------------------------------------------------------------------
//  channel   | handshake            | payload
//  ----------+----------------------+--------------------------------------
//  bone in   | start / busy         | rest_*, pose_* start and end points
//  config    | cfg_write            | cfg_data (degenerate threshold)
//  rows out  | done per row         | row_index, rot_col_a..c, shift_part,
//            |                      | last_row, degenerate
//
// A bone is taken only while busy is low; busy goes high after each accepted beat.
// Row 0 appears once its bone has passed every stage, rows 1 and 2 follow.
// The path runs through the 32-step root pipeline and the FRAC_BITS + 1 step
// fraction dividers; every stage moves one step per cycle.
// Synchronous active-high rst clears the pipeline valid bits, busy, the row
// sequencer and sets the threshold to 1. Rows cannot be held off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bone_transform_matrix_core
  import btm_pkg::*;
#(
  parameter int FRAC_BITS   = 16,
  parameter int COORD_WIDTH = 24
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           start,
  output logic                          busy,
  input  wire signed [COORD_WIDTH-1:0]  rest_start_x,
  input  wire signed [COORD_WIDTH-1:0]  rest_start_y,
  input  wire signed [COORD_WIDTH-1:0]  rest_start_z,
  input  wire signed [COORD_WIDTH-1:0]  rest_end_x,
  input  wire signed [COORD_WIDTH-1:0]  rest_end_y,
  input  wire signed [COORD_WIDTH-1:0]  rest_end_z,
  input  wire signed [COORD_WIDTH-1:0]  pose_start_x,
  input  wire signed [COORD_WIDTH-1:0]  pose_start_y,
  input  wire signed [COORD_WIDTH-1:0]  pose_start_z,
  input  wire signed [COORD_WIDTH-1:0]  pose_end_x,
  input  wire signed [COORD_WIDTH-1:0]  pose_end_y,
  input  wire signed [COORD_WIDTH-1:0]  pose_end_z,
  input  wire                           cfg_write,
  input  wire        [15:0]             cfg_data,
  output logic                          done,
  output logic       [1:0]              row_index,
  output logic signed [OW-1:0]          rot_col_a,
  output logic signed [OW-1:0]          rot_col_b,
  output logic signed [OW-1:0]          rot_col_c,
  output logic signed [TW-1:0]          shift_part,
  output logic                          last_row,
  output logic                          degenerate
);

  localparam int SH  = (COORD_WIDTH > 24) ? COORD_WIDTH - 24 : 0;
  localparam int QW  = FRAC_BITS + 1;
  localparam int NW  = FRAC_BITS + 2;
  localparam int MW  = 2 * NW;
  localparam int OMW = FRAC_BITS + 3;
  localparam int PMW = OMW + NW;
  localparam int RV  = FRAC_BITS + 4;
  localparam int XW  = (RV > OW) ? RV : OW;
  localparam int NST = FRAC_BITS + 49;

  localparam logic [QW-1:0]        ONE_Q = QW'(1) << FRAC_BITS;
  localparam logic signed [RV-1:0] ONE_R = RV'(1) << FRAC_BITS;
  localparam logic signed [MW-1:0]  HALF_M = MW'(1) << (FRAC_BITS - 1);
  localparam logic signed [PMW-1:0] HALF_P = PMW'(1) << (FRAC_BITS - 1);

  function automatic logic signed [RW-1:0] prescale(input logic signed [DFW-1:0] x);
    logic [DFW-1:0] a;
    a = x[DFW-1] ? DFW'(-x) : DFW'(x);
    a = a >> SH;
    return x[DFW-1] ? RW'(-a) : RW'(a);
  endfunction

  function automatic logic [TW-1:0] sat_t(input logic signed [DFW-1:0] x);
    logic [TW-1:0] y;
    if (x > T_MAX) y = T_MAX[TW-1:0];
    else if (x < T_MIN) y = T_MIN[TW-1:0];
    else y = x[TW-1:0];
    return y;
  endfunction

  function automatic logic signed [NW-1:0] rnd_n(input logic signed [MW-1:0] x);
    logic signed [MW-1:0] y;
    y = x + HALF_M;
    return NW'(y >>> FRAC_BITS);
  endfunction

  function automatic logic signed [RV-1:0] rnd_p(input logic signed [PMW-1:0] x);
    logic signed [PMW-1:0] y;
    y = x + HALF_P;
    return RV'(y >>> FRAC_BITS);
  endfunction

  // control
  logic [15:0]    thr;
  logic [1:0]     bcnt;
  logic           acc;
  logic [NST-1:0] vld;

  assign busy = (bcnt != 2'd0);
  assign acc  = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr  <= THR_RESET;
      bcnt <= 2'd0;
      vld  <= '0;
    end else begin
      if (cfg_write) thr <= cfg_data;
      if (acc) bcnt <= 2'd2;
      else if (bcnt != 2'd0) bcnt <= bcnt - 2'd1;
      vld <= {vld[NST-2:0], acc};
    end
  end

  logic signed [COORD_WIDTH-1:0] rs [3], re [3], ps [3], pe [3];
  assign rs[0] = rest_start_x;
  assign rs[1] = rest_start_y;
  assign rs[2] = rest_start_z;
  assign re[0] = rest_end_x;
  assign re[1] = rest_end_y;
  assign re[2] = rest_end_z;
  assign ps[0] = pose_start_x;
  assign ps[1] = pose_start_y;
  assign ps[2] = pose_start_z;
  assign pe[0] = pose_end_x;
  assign pe[1] = pose_end_y;
  assign pe[2] = pose_end_z;

  // s1: bone vectors and translation
  logic signed [RW-1:0] r1 [3], m1 [3];
  side_t sd1;
  always_ff @(posedge clk) begin
    logic signed [DFW-1:0] dr, dm, dt;
    side_t nx;
    nx = '0;
    for (int i = 0; i < 3; i++) begin
      dr = DFW'(re[i]) - DFW'(rs[i]);
      dm = DFW'(pe[i]) - DFW'(ps[i]);
      dt = DFW'(ps[i]) - DFW'(rs[i]);
      r1[i] <= prescale(dr);
      m1[i] <= prescale(dm);
      nx.t[i] = sat_t(dt);
    end
    sd1 <= nx;
  end

  // s2: products
  logic signed [PW-1:0] p2 [3][3], rq2 [3], mq2 [3];
  side_t sd2;
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) p2[i][j] <= r1[i] * m1[j];
      rq2[i] <= r1[i] * r1[i];
      mq2[i] <= m1[i] * m1[i];
    end
    sd2 <= sd1;
  end

  // s3: cross, dot, squared lengths
  logic signed [KW-1:0]  k3 [3];
  logic signed [DTW-1:0] d3;
  logic [PW-1:0] sr3, sm3;
  side_t sd3;
  always_ff @(posedge clk) begin
    k3[0] <= KW'(p2[1][2]) - KW'(p2[2][1]);
    k3[1] <= KW'(p2[2][0]) - KW'(p2[0][2]);
    k3[2] <= KW'(p2[0][1]) - KW'(p2[1][0]);
    d3    <= DTW'(p2[0][0]) + DTW'(p2[1][1]) + DTW'(p2[2][2]);
    sr3   <= rq2[0] + rq2[1] + rq2[2];
    sm3   <= mq2[0] + mq2[1] + mq2[2];
    sd3   <= sd2;
  end

  // s4: magnitudes and signs
  logic [PW-1:0] sr4, sm4;
  side_t sd4;
  always_ff @(posedge clk) begin
    side_t nx;
    nx = sd3;
    for (int i = 0; i < 3; i++) begin
      nx.kneg[i] = k3[i][KW-1];
      nx.kmag[i] = k3[i][KW-1] ? PW'(-k3[i]) : PW'(k3[i]);
    end
    nx.dneg = d3[DTW-1];
    nx.dmag = d3[DTW-1] ? PW'(-d3) : PW'(d3);
    sd4 <= nx;
    sr4 <= sr3;
    sm4 <= sm3;
  end

  // s5: shift that brings every cross component below 2^31
  logic [PW-1:0] sr5, sm5;
  side_t sd5;
  always_ff @(posedge clk) begin
    side_t nx;
    logic [PW-1:0] orv;
    nx  = sd4;
    orv = sd4.kmag[0] | sd4.kmag[1] | sd4.kmag[2];
    nx.e = '0;
    for (int b = 0; b < EXB; b++)
      if (orv[KTW + b]) nx.e = EW'(b + 1);
    sd5 <= nx;
    sr5 <= sr4;
    sm5 <= sm4;
  end

  // s6: shifted cross magnitudes
  logic [KTW-1:0] kt6 [3];
  logic [PW-1:0] sr6, sm6;
  side_t sd6;
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) kt6[i] <= KTW'(sd5.kmag[i] >> sd5.e);
    sr6 <= sr5;
    sm6 <= sm5;
    sd6 <= sd5;
  end

  // s7: squares of shifted cross
  logic [2*KTW-1:0] kq7 [3];
  logic [PW-1:0] sr7, sm7;
  side_t sd7;
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) kq7[i] <= kt6[i] * kt6[i];
    sr7 <= sr6;
    sm7 <= sm6;
    sd7 <= sd6;
  end

  // root pipeline, lanes: |r|^2, |m|^2, shifted |k|^2; index 0 is s8
  logic [SQW-1:0] sq_v   [SQN+1][3];
  logic [RMW-1:0] sq_rem [SQN+1][3];
  logic [SQN-1:0] sq_res [SQN+1][3];
  side_t          sd_q   [SQN+1];

  always_ff @(posedge clk) begin
    sq_v[0][0] <= SQW'(sr7);
    sq_v[0][1] <= SQW'(sm7);
    sq_v[0][2] <= SQW'(kq7[0]) + SQW'(kq7[1]) + SQW'(kq7[2]);
    for (int l = 0; l < 3; l++) begin
      sq_rem[0][l] <= '0;
      sq_res[0][l] <= '0;
    end
    sd_q[0] <= sd7;
  end

  for (genvar j = 0; j < SQN; j++) begin : g_sqrt
    always_ff @(posedge clk) begin
      logic [RMW+1:0] remx, trial;
      for (int l = 0; l < 3; l++) begin
        remx  = {sq_rem[j][l], sq_v[j][l][SQW-1 -: 2]};
        trial = {2'b00, sq_res[j][l], 2'b01};
        if (remx >= trial) begin
          sq_rem[j+1][l] <= RMW'(remx - trial);
          sq_res[j+1][l] <= {sq_res[j][l][SQN-2:0], 1'b1};
        end else begin
          sq_rem[j+1][l] <= RMW'(remx);
          sq_res[j+1][l] <= {sq_res[j][l][SQN-2:0], 1'b0};
        end
        sq_v[j+1][l] <= {sq_v[j][l][SQW-3:0], 2'b00};
      end
      sd_q[j+1] <= sd_q[j];
    end
  end

  // stage a: lengths and degenerate test
  logic [RW-1:0]  lr_a, lm_a;
  logic [LKW-1:0] lk_a;
  side_t sd_a;
  always_ff @(posedge clk) begin
    logic [LKW-1:0] lk;
    side_t nx;
    lk = LKW'(sq_res[SQN][2]) << sd_q[SQN].e;
    nx = sd_q[SQN];
    nx.degen = (sq_res[SQN][0] <= SQN'(thr)) || (sq_res[SQN][1] <= SQN'(thr)) ||
               ((lk >> FRAC_BITS) <= LKW'(thr));
    lr_a <= sq_res[SQN][0][RW-1:0];
    lm_a <= sq_res[SQN][1][RW-1:0];
    lk_a <= lk;
    sd_a <= nx;
  end

  // stage b: common denominator
  logic [PW-1:0]  den_b;
  logic [LKW-1:0] lk_b;
  side_t sd_b;
  always_ff @(posedge clk) begin
    den_b <= lr_a * lm_a;
    lk_b  <= lk_a;
    sd_b  <= sd_a;
  end

  // fraction dividers, lanes: c, s, n0, n1, n2
  logic [DVW-1:0] dv_rem [FRAC_BITS+1][NDIV];
  logic [DVW-1:0] dv_den [FRAC_BITS+1][NDIV];
  logic [QW-1:0]  dv_q   [FRAC_BITS+1][NDIV];
  logic           dv_sat [FRAC_BITS+1][NDIV];
  side_t          dv_sd  [FRAC_BITS+1];

  always_ff @(posedge clk) begin
    logic [DVW-1:0] num [NDIV];
    logic [DVW-1:0] den [NDIV];
    num[0] = DVW'(sd_b.dmag);
    den[0] = DVW'(den_b);
    num[1] = DVW'(lk_b);
    den[1] = DVW'(den_b);
    for (int i = 0; i < 3; i++) begin
      num[2+i] = DVW'(sd_b.kmag[i]);
      den[2+i] = DVW'(lk_b);
    end
    for (int l = 0; l < NDIV; l++) begin
      // two or more whole units always saturates
      dv_sat[0][l] <= num[l] >= (den[l] << 1);
      if (num[l] >= den[l]) begin
        dv_q[0][l]   <= QW'(1);
        dv_rem[0][l] <= num[l] - den[l];
      end else begin
        dv_q[0][l]   <= '0;
        dv_rem[0][l] <= num[l];
      end
      dv_den[0][l] <= den[l];
    end
    dv_sd[0] <= sd_b;
  end

  for (genvar j = 0; j < FRAC_BITS; j++) begin : g_div
    always_ff @(posedge clk) begin
      logic [DVW-1:0] r2;
      logic           ge;
      for (int l = 0; l < NDIV; l++) begin
        r2 = {dv_rem[j][l][DVW-2:0], 1'b0};
        ge = r2 >= dv_den[j][l];
        dv_rem[j+1][l] <= ge ? r2 - dv_den[j][l] : r2;
        dv_q[j+1][l]   <= {dv_q[j][l][QW-2:0], ge};
        dv_den[j+1][l] <= dv_den[j][l];
        dv_sat[j+1][l] <= dv_sat[j][l];
      end
      dv_sd[j+1] <= dv_sd[j];
    end
  end

  // r0: cap and sign
  logic signed [NW-1:0]  c_r0, s_r0, n_r0 [3];
  logic signed [OMW-1:0] omc_r0;
  side_t sd_r0;
  always_ff @(posedge clk) begin
    logic [QW-1:0] mg [NDIV];
    logic signed [NW-1:0] cv;
    for (int l = 0; l < NDIV; l++)
      mg[l] = (dv_sat[FRAC_BITS][l] || dv_q[FRAC_BITS][l] > ONE_Q) ? ONE_Q
                                                                     : dv_q[FRAC_BITS][l];
    cv = dv_sd[FRAC_BITS].dneg ? -NW'(mg[0]) : NW'(mg[0]);
    c_r0   <= cv;
    omc_r0 <= OMW'(ONE_Q) - OMW'(cv);
    s_r0   <= NW'(mg[1]);
    for (int i = 0; i < 3; i++)
      n_r0[i] <= dv_sd[FRAC_BITS].kneg[i] ? -NW'(mg[2+i]) : NW'(mg[2+i]);
    sd_r0 <= dv_sd[FRAC_BITS];
  end

  // r1: raw axis products
  logic signed [MW-1:0]  nn_r1 [3][3], sn_r1 [3];
  logic signed [NW-1:0]  c_r1;
  logic signed [OMW-1:0] omc_r1;
  side_t sd_r1;
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) nn_r1[i][j] <= n_r0[i] * n_r0[j];
      sn_r1[i] <= s_r0 * n_r0[i];
    end
    c_r1   <= c_r0;
    omc_r1 <= omc_r0;
    sd_r1  <= sd_r0;
  end

  // r2: round half up
  logic signed [NW-1:0]  nn_r2 [3][3], sn_r2 [3];
  logic signed [NW-1:0]  c_r2;
  logic signed [OMW-1:0] omc_r2;
  side_t sd_r2;
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) nn_r2[i][j] <= rnd_n(nn_r1[i][j]);
      sn_r2[i] <= rnd_n(sn_r1[i]);
    end
    c_r2   <= c_r1;
    omc_r2 <= omc_r1;
    sd_r2  <= sd_r1;
  end

  // r3: (1 - c) times outer product
  logic signed [PMW-1:0] pp_r3 [3][3];
  logic signed [NW-1:0]  c_r3, sn_r3 [3];
  side_t sd_r3;
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) pp_r3[i][j] <= omc_r2 * nn_r2[i][j];
      sn_r3[i] <= sn_r2[i];
    end
    c_r3  <= c_r2;
    sd_r3 <= sd_r2;
  end

  // r4: sum of the three Rodrigues terms
  logic signed [RV-1:0] rot_r4 [3][3];
  side_t sd_r4;
  always_ff @(posedge clk) begin
    logic signed [RV-1:0] v [3][3];
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        v[i][j] = rnd_p(pp_r3[i][j]);
        if (i == j) v[i][j] = v[i][j] + RV'(c_r3);
      end
    // skew part s*[n]x
    v[0][1] = v[0][1] - RV'(sn_r3[2]);
    v[0][2] = v[0][2] + RV'(sn_r3[1]);
    v[1][0] = v[1][0] + RV'(sn_r3[2]);
    v[1][2] = v[1][2] - RV'(sn_r3[0]);
    v[2][0] = v[2][0] - RV'(sn_r3[1]);
    v[2][1] = v[2][1] + RV'(sn_r3[0]);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) rot_r4[i][j] <= v[i][j];
    sd_r4 <= sd_r3;
  end

  // r5: clamp, identity on degenerate, port width
  logic [OW-1:0] rot_r5 [3][3];
  side_t sd_r5;
  always_ff @(posedge clk) begin
    logic signed [RV-1:0] cv;
    logic signed [XW-1:0] w;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        if (sd_r4.degen) cv = (i == j) ? ONE_R : '0;
        else if (rot_r4[i][j] > ONE_R) cv = ONE_R;
        else if (rot_r4[i][j] < -ONE_R) cv = -ONE_R;
        else cv = rot_r4[i][j];
        w = XW'(cv);
        rot_r5[i][j] <= w[OW-1:0];
      end
    sd_r5 <= sd_r4;
  end

  // row sequencer
  logic [OW-1:0] hold_rot [3][3];
  logic [TW-1:0] hold_t [3];
  logic          hold_degen;
  logic [1:0]    ocnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      ocnt <= ROW_FIRST;
    end else if (vld[NST-1]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) hold_rot[i][j] <= rot_r5[i][j];
        hold_t[i] <= sd_r5.t[i];
      end
      hold_degen <= sd_r5.degen;
      done       <= 1'b1;
      row_index  <= ROW_FIRST;
      rot_col_a  <= rot_r5[0][0];
      rot_col_b  <= rot_r5[0][1];
      rot_col_c  <= rot_r5[0][2];
      shift_part <= sd_r5.t[0];
      last_row   <= 1'b0;
      degenerate <= sd_r5.degen;
      ocnt       <= ROW_MID;
    end else if (ocnt != ROW_FIRST) begin
      done       <= 1'b1;
      row_index  <= ocnt;
      rot_col_a  <= hold_rot[ocnt][0];
      rot_col_b  <= hold_rot[ocnt][1];
      rot_col_c  <= hold_rot[ocnt][2];
      shift_part <= hold_t[ocnt];
      last_row   <= (ocnt == ROW_LAST);
      degenerate <= hold_degen;
      ocnt       <= (ocnt == ROW_LAST) ? ROW_FIRST : ocnt + 2'd1;
    end else begin
      done <= 1'b0;
    end
  end

`ifndef SYNTH
  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after an input beat");

  a_row_order: assert property (@(posedge clk) disable iff (rst)
    done && row_index == ROW_FIRST |=> done && row_index == ROW_MID ##1
                                      done && row_index == ROW_LAST)
    else $error("rows of one bone not delivered back to back");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    done |-> last_row == (row_index == ROW_LAST))
    else $error("last_row does not match row_index");

  a_degen_identity: assert property (@(posedge clk) disable iff (rst)
    done && degenerate && row_index == ROW_FIRST |-> rot_col_b == '0 && rot_col_c == '0)
    else $error("degenerate row is not identity");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    vld[NST-1] |-> !done || last_row)
    else $error("new bone reached the row sequencer mid-item");
`endif

endmodule

`default_nettype wire

@@ tb/sv/bone_transform_matrix_core_test.sv @@
// ----------------------------------------------------------------------------
// bone_transform_matrix_core_test
// Drives bones through the start/busy port and checks every matrix row against
// a fixed-point Rodrigues predictor kept in the bench, across threshold values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bone_transform_matrix_core_test;
  import btm_pkg::*;

  localparam int FB = 16;
  localparam longint ONE = 64'sd1 <<< FB;
  localparam int LIMIT = 200000;

  typedef struct {
    logic signed [23:0] p [12];
  } bone_t;

  typedef struct {
    logic [1:0]        row;
    logic [OW-1:0]     ca, cb, cc;
    logic [TW-1:0]     sh;
    logic              last, degen;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic signed [23:0] pin [12];
  logic cfg_write = 1'b0;
  logic [15:0] cfg_data = 16'd0;
  wire busy, done, last_row, degenerate;
  wire [1:0] row_index;
  wire signed [OW-1:0] rot_col_a, rot_col_b, rot_col_c;
  wire signed [TW-1:0] shift_part;

  bone_t pending_bones [$];
  row_t  expected_rows [$];
  logic [15:0] threshold;
  int    errors = 0;
  int    cycles = 0;
  bit    calm;

  initial for (int i = 0; i < 12; i++) pin[i] = '0;

  always #10 clk = ~clk;

  bone_transform_matrix_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .rest_start_x(pin[0]), .rest_start_y(pin[1]), .rest_start_z(pin[2]),
    .rest_end_x(pin[3]), .rest_end_y(pin[4]), .rest_end_z(pin[5]),
    .pose_start_x(pin[6]), .pose_start_y(pin[7]), .pose_start_z(pin[8]),
    .pose_end_x(pin[9]), .pose_end_y(pin[10]), .pose_end_z(pin[11]),
    .cfg_write(cfg_write), .cfg_data(cfg_data), .done(done),
    .row_index(row_index), .rot_col_a(rot_col_a), .rot_col_b(rot_col_b),
    .rot_col_c(rot_col_c), .shift_part(shift_part), .last_row(last_row),
    .degenerate(degenerate)
  );

  function automatic longint unsigned magof(longint x);
    return x < 0 ? -x : x;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint fix_mul(longint a, longint b);
    longint y;
    y = a * b + (ONE >>> 1);
    if (y >= 0) return y >>> FB;
    return -longint'((magof(y) + longint'(ONE - 1)) >> FB);
  endfunction

  // fraction of num/den with FB bits, capped at one
  function automatic longint unit_ratio(longint unsigned num, longint unsigned den);
    longint unsigned q, rm;
    if (den == 0) return 0;
    q = num / den;
    rm = num % den;
    if (q >= 2) return ONE;
    for (int i = 0; i < FB; i++) begin
      rm <<= 1;
      q <<= 1;
      if (rm >= den) begin
        rm -= den;
        q |= 1;
      end
    end
    return q > ONE ? ONE : longint'(q);
  endfunction

  task automatic predict_rows(bone_t b);
    longint r[3], m[3], k[3], n[3], t[3], rot[3][3];
    longint d, c, s, omc;
    longint unsigned lr, lm, lk, mx, sum;
    int e;
    bit dg;
    row_t o;
    for (int i = 0; i < 3; i++) begin
      r[i] = longint'(b.p[3+i]) - longint'(b.p[i]);
      m[i] = longint'(b.p[9+i]) - longint'(b.p[6+i]);
      t[i] = longint'(b.p[6+i]) - longint'(b.p[i]);
    end
    k[0] = r[1]*m[2] - r[2]*m[1];
    k[1] = r[2]*m[0] - r[0]*m[2];
    k[2] = r[0]*m[1] - r[1]*m[0];
    d = r[0]*m[0] + r[1]*m[1] + r[2]*m[2];
    lr = root_floor(magof(r[0])**2 + magof(r[1])**2 + magof(r[2])**2);
    lm = root_floor(magof(m[0])**2 + magof(m[1])**2 + magof(m[2])**2);
    mx = magof(k[0]);
    if (magof(k[1]) > mx) mx = magof(k[1]);
    if (magof(k[2]) > mx) mx = magof(k[2]);
    e = 0;
    while ((mx >> e) >= (64'd1 << 31)) e++;
    sum = 0;
    for (int i = 0; i < 3; i++) sum += (magof(k[i]) >> e) * (magof(k[i]) >> e);
    lk = root_floor(sum) << e;
    dg = lr <= threshold || lm <= threshold || (lk >> FB) <= threshold;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) rot[i][j] = (i == j) ? ONE : 0;
    if (!dg) begin
      c = unit_ratio(magof(d), lr * lm);
      if (d < 0) c = -c;
      s = unit_ratio(lk, lr * lm);
      for (int i = 0; i < 3; i++) begin
        n[i] = unit_ratio(magof(k[i]), lk);
        if (k[i] < 0) n[i] = -n[i];
      end
      omc = ONE - c;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          rot[i][j] = fix_mul(omc, fix_mul(n[i], n[j])) + ((i == j) ? c : 0);
      rot[0][1] -= fix_mul(s, n[2]);
      rot[0][2] += fix_mul(s, n[1]);
      rot[1][0] += fix_mul(s, n[2]);
      rot[1][2] -= fix_mul(s, n[0]);
      rot[2][0] -= fix_mul(s, n[1]);
      rot[2][1] += fix_mul(s, n[0]);
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) begin
          if (rot[i][j] > ONE) rot[i][j] = ONE;
          if (rot[i][j] < -ONE) rot[i][j] = -ONE;
        end
    end
    for (int i = 0; i < 3; i++) begin
      o.row = i[1:0];
      o.ca = rot[i][0][OW-1:0];
      o.cb = rot[i][1][OW-1:0];
      o.cc = rot[i][2][OW-1:0];
      o.sh = t[i][TW-1:0];
      o.last = (i == 2);
      o.degen = dg;
      expected_rows.push_back(o);
    end
  endtask

  task automatic report_mismatch(string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  // driver: predict on the accepting edge, then present the next bone
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) predict_rows(bone_t'{p: pin});
      if (!(start && busy)) begin
        if (pending_bones.size() > 0 && (calm || $urandom_range(99) >= 19)) begin
          bone_t b;
          b = pending_bones.pop_front();
          for (int i = 0; i < 12; i++) pin[i] <= b.p[i];
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cycles++;
    if (!rst && done) begin
      if (expected_rows.size() == 0) begin
        report_mismatch("row with nothing expected");
      end else begin
        row_t x;
        x = expected_rows.pop_front();
        if (row_index !== x.row) report_mismatch($sformatf("row_index %0d exp %0d", row_index, x.row));
        if (rot_col_a !== x.ca) report_mismatch($sformatf("rot_col_a %h exp %h", rot_col_a, x.ca));
        if (rot_col_b !== x.cb) report_mismatch($sformatf("rot_col_b %h exp %h", rot_col_b, x.cb));
        if (rot_col_c !== x.cc) report_mismatch($sformatf("rot_col_c %h exp %h", rot_col_c, x.cc));
        if (shift_part !== x.sh) report_mismatch($sformatf("shift_part %h exp %h", shift_part, x.sh));
        if (last_row !== x.last) report_mismatch("last_row");
        if (degenerate !== x.degen) report_mismatch("degenerate");
      end
    end
    if (cycles > LIMIT) begin
      $display("bone_transform_matrix_core_test: FAIL");
      $finish;
    end
  end

  function automatic bone_t rand_bone(int span);
    bone_t b;
    for (int i = 0; i < 12; i++) begin
      b.p[i] = (span >= 24) ? 24'($urandom) : 24'($signed($urandom_range(2*(1 << span)) - (1 << span)));
    end
    return b;
  endfunction

  function automatic bone_t make_bone(int rs, int re[3], int ps, int pe[3]);
    bone_t b;
    for (int i = 0; i < 3; i++) begin
      b.p[i] = 24'(rs);
      b.p[3+i] = 24'(rs + re[i]);
      b.p[6+i] = 24'(ps);
      b.p[9+i] = 24'(ps + pe[i]);
    end
    return b;
  endfunction

  task automatic write_threshold(logic [15:0] v);
    @(posedge clk);
    cfg_data <= v;
    cfg_write <= 1'b1;
    threshold = v;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic drain;
    while (pending_bones.size() > 0 || start || expected_rows.size() > 0) @(posedge clk);
    repeat (FB + 60) @(posedge clk);
  endtask

  initial begin
    bone_t b;
    logic [15:0] thr_set [5];
    thr_set = '{16'd0, 16'd1, 16'd65535, 16'd300, 16'd1};
    threshold = THR_RESET;
    calm = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, zero vectors, parallel, opposite, orthogonal
    b = rand_bone(24);
    for (int i = 0; i < 12; i++) b.p[i] = (i < 6) ? 24'sh800000 : 24'sh7fffff;
    pending_bones.push_back(b);
    for (int i = 0; i < 12; i++) b.p[i] = (i < 6) ? 24'sh7fffff : 24'sh800000;
    pending_bones.push_back(b);
    for (int i = 0; i < 12; i++) b.p[i] = (i % 6 < 3) ? 24'sh7fffff : 24'sh800000;
    pending_bones.push_back(b);
    for (int i = 0; i < 12; i++) b.p[i] = 0;
    pending_bones.push_back(b);
    pending_bones.push_back(make_bone(100, '{1000, 0, 0}, -50, '{3000, 0, 0}));
    pending_bones.push_back(make_bone(0, '{1000, 0, 0}, 0, '{-2000, 0, 0}));
    pending_bones.push_back(make_bone(7, '{65536, 0, 0}, 9, '{0, 65536, 0}));
    pending_bones.push_back(make_bone(-3, '{0, 65536, 0}, 0, '{0, 0, -65536}));
    pending_bones.push_back(make_bone(0, '{300000, 200000, 0}, 5, '{-100000, 400000, 9000}));
    pending_bones.push_back(make_bone(0, '{1, 0, 0}, 0, '{0, 1, 0}));
    pending_bones.push_back(make_bone(0, '{3000000, 1, 0}, 0, '{3000000, 2, 0}));
    for (int i = 0; i < 6; i++) pending_bones.push_back(rand_bone(24));
    drain();

    // random phases across thresholds, with one calm stretch
    foreach (thr_set[ph]) begin
      write_threshold(thr_set[ph]);
      calm = (ph == 3);
      for (int i = 0; i < 19; i++) begin
        int pick;
        pick = $urandom_range(9);
        if (pick < 4) pending_bones.push_back(rand_bone(24));
        else if (pick < 8) pending_bones.push_back(rand_bone($urandom_range(22, 10)));
        else pending_bones.push_back(rand_bone($urandom_range(4, 0)));
      end
      drain();
    end

    if (errors == 0) begin
      $display("bone_transform_matrix_core_test: PASS");
    end else begin
      $display("bone_transform_matrix_core_test: FAIL");
    end
    $finish;
  end

endmodule
